### src/lkv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lkv_pkg;

   // Slot count of the fully associative store
   localparam int ENTRIES = 16;
   // Age holds 0..ENTRIES-1, count holds 0..ENTRIES
   localparam int SLOT_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int COUNT_W = $clog2(ENTRIES + 1);
   localparam int KEY_W   = 32;
   localparam int DATA_W  = 32;
   localparam int CAP_W   = 5;

   localparam logic [CAP_W-1:0]  CAP_RESET  = 5'd16;
   localparam logic [DATA_W-1:0] MISS_VALUE = '1;
   localparam logic [DATA_W-1:0] PUT_VALUE  = '0;

   localparam logic KIND_GET = 1'b0;
   localparam logic KIND_PUT = 1'b1;

   typedef logic [ENTRIES-1:0] slot_vec_type;

   // Operation seen by the recency tracker in the processing cycle
   typedef struct packed {
      logic fire;
      logic put;
      logic hit;
   } op_type;

   // Write request into the key/value store
   typedef struct packed {
      logic         write_key;
      logic         write_value;
      slot_vec_type slot;
   } wr_type;

endpackage

`default_nettype wire

### src/lkv_entries.sv
`timescale 1ns / 1ps
`default_nettype none

module lkv_entries (
   input  wire                         clock,
   input  wire                         reset,
   input  lkv_pkg::wr_type             upd,
   input  wire [lkv_pkg::KEY_W-1:0]    key,
   input  wire [lkv_pkg::DATA_W-1:0]   value,
   output lkv_pkg::slot_vec_type       valid_vec,
   output lkv_pkg::slot_vec_type       hit_vec,
   output logic [lkv_pkg::DATA_W-1:0]  hit_value
);
   import lkv_pkg::*;

   logic [KEY_W-1:0]  key_ff   [ENTRIES];
   logic [DATA_W-1:0] value_ff [ENTRIES];
   slot_vec_type      valid_ff;
   slot_vec_type      valid_in;

   assign valid_vec = valid_ff;

   // Compare the key against every slot in parallel
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         hit_vec[i] = valid_ff[i] && (key_ff[i] == key);
      end
   end

   // Select the stored value of the matching slot
   always_comb begin
      hit_value = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         hit_value = hit_value | (hit_vec[i] ? value_ff[i] : '0);
      end
   end

   assign valid_in = upd.write_key ? (valid_ff | upd.slot) : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < ENTRIES; i++) begin
         if (upd.write_key && upd.slot[i]) begin
            key_ff[i] <= key;
         end
         if (upd.write_value && upd.slot[i]) begin
            value_ff[i] <= value;
         end
      end
   end

   // A put that hits updates in place, so a key sits in one slot at most
   a_unique_key: assert property (@(posedge clock) disable iff (reset)
      $onehot0(hit_vec))
      else $error("key matches more than one slot");

   a_write_onehot: assert property (@(posedge clock) disable iff (reset)
      (upd.write_key || upd.write_value) |-> $onehot(upd.slot))
      else $error("store write without a single target slot");

endmodule

`default_nettype wire

### src/lkv_recency.sv
`timescale 1ns / 1ps
`default_nettype none

module lkv_recency (
   input  wire                       clock,
   input  wire                       reset,
   input  lkv_pkg::op_type           op,
   input  lkv_pkg::slot_vec_type     hit_vec,
   input  lkv_pkg::slot_vec_type     valid_vec,
   input  wire [lkv_pkg::CAP_W-1:0]  capacity,
   output lkv_pkg::slot_vec_type     slot_vec
);
   import lkv_pkg::*;

   logic [SLOT_W-1:0]  age_ff [ENTRIES];
   logic [SLOT_W-1:0]  age_in [ENTRIES];
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic [COUNT_W-1:0] count_dec;
   logic [SLOT_W-1:0]  oldest_age;
   logic [SLOT_W-1:0]  hit_age;
   slot_vec_type       oldest_vec;
   slot_vec_type       free_vec;
   slot_vec_type       first_free;
   logic               full;
   logic               insert;

   // Count reached the clamped capacity: zero counts as one, above ENTRIES saturates
   always_comb begin
      if (capacity == '0) begin
         full = (count_ff != '0);
      end else begin
         full = (32'(count_ff) >= 32'(capacity)) || (32'(count_ff) >= 32'(ENTRIES));
      end
   end

   // Ages of valid slots are a permutation of 0..count-1: the oldest has age count-1
   assign count_dec  = count_ff - COUNT_W'(1);
   assign oldest_age = count_dec[SLOT_W-1:0];

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         oldest_vec[i] = valid_vec[i] && (age_ff[i] == oldest_age);
      end
   end

   // Isolate the lowest free slot
   assign free_vec   = ~valid_vec;
   assign first_free = free_vec & (~free_vec + slot_vec_type'(1));

   assign slot_vec = op.hit ? hit_vec : (full ? oldest_vec : first_free);
   assign insert   = op.fire && op.put && !op.hit;

   always_comb begin
      hit_age = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         hit_age = hit_age | (hit_vec[i] ? age_ff[i] : '0);
      end
   end

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         age_in[i] = age_ff[i];
         if (op.fire && op.hit) begin
            if (slot_vec[i]) begin
               age_in[i] = '0;
            end else if (valid_vec[i] && (age_ff[i] < hit_age)) begin
               age_in[i] = age_ff[i] + SLOT_W'(1);
            end
         end else if (insert) begin
            if (slot_vec[i]) begin
               age_in[i] = '0;
            end else if (valid_vec[i]) begin
               age_in[i] = age_ff[i] + SLOT_W'(1);
            end
         end
      end
   end

   // Grow only when the new pair lands in a free slot
   assign count_in = (insert && ((slot_vec & valid_vec) == '0))
                   ? count_ff + COUNT_W'(1) : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            age_ff[i] <= '0;
         end
      end else begin
         count_ff <= count_in;
         for (int i = 0; i < ENTRIES; i++) begin
            age_ff[i] <= age_in[i];
         end
      end
   end

   a_count_tracks_valid: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == 32'(count_ff))
      else $error("entry count disagrees with valid bits");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (insert && !full) |=> (count_ff == $past(count_ff) + COUNT_W'(1)))
      else $error("insert below capacity did not grow the count");

endmodule

`default_nettype wire

### src/lru_key_value_cache.sv
// Flow: an accepted item waits in the input register, then its lookup and
// update write the result register, where the result is offered until taken.
// Throughput: one item per cycle while the result is not stalled; the tag
// compare, victim select and age update of all slots settle combinationally
// between the two registers.
// Reset: valid bits, ages and entry count clear at once, capacity returns
// to 16; key and value storage is not cleared and no sweep runs.
`timescale 1ns / 1ps
`default_nettype none

module lru_key_value_cache (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_stall,
   input  wire                              req_kind,
   input  wire signed [lkv_pkg::KEY_W-1:0]  req_key,
   input  wire signed [lkv_pkg::DATA_W-1:0] req_value,
   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output logic                             rsp_hit,
   output logic signed [lkv_pkg::DATA_W-1:0] rsp_read_value,
   input  wire                              csr_valid,
   output logic                             csr_ready,
   input  wire [lkv_pkg::CAP_W-1:0]         csr_data
);
   import lkv_pkg::*;

   // Input register
   logic              stage_valid_ff;
   logic              stage_valid_in;
   logic              stage_kind_ff;
   logic [KEY_W-1:0]  stage_key_ff;
   logic [DATA_W-1:0] stage_value_ff;

   // Result register
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic              rsp_hit_ff;
   logic [DATA_W-1:0] rsp_read_value_ff;
   logic [DATA_W-1:0] rsp_read_value_in;

   logic [CAP_W-1:0]  capacity_ff;

   logic              req_accept;
   logic              advance;
   logic              hit;
   logic              is_put;
   logic [DATA_W-1:0] hit_value;
   slot_vec_type      valid_vec;
   slot_vec_type      hit_vec;
   slot_vec_type      slot_vec;
   op_type            op;
   wr_type            upd;

   // Process the staged item whenever the result register is free or draining
   assign advance    = stage_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = stage_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else if (csr_valid && csr_ready) begin
         capacity_ff <= csr_data;
      end
   end

   // Load a new item, or drop the one just processed
   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (req_accept) begin
         stage_valid_in = 1'b1;
      end else if (advance) begin
         stage_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         stage_kind_ff  <= req_kind;
         stage_key_ff   <= req_key;
         stage_value_ff <= req_value;
      end
   end

   assign is_put = (stage_kind_ff == KIND_PUT);
   assign hit    = |hit_vec;

   assign op.fire = advance;
   assign op.put  = is_put;
   assign op.hit  = hit;

   // Write the value on any put; write the key only when a new pair goes in
   assign upd.write_key   = advance && is_put && !hit;
   assign upd.write_value = advance && is_put;
   assign upd.slot        = slot_vec;

   lkv_entries u_entries (
      .clock     (clock),
      .reset     (reset),
      .upd       (upd),
      .key       (stage_key_ff),
      .value     (stage_value_ff),
      .valid_vec (valid_vec),
      .hit_vec   (hit_vec),
      .hit_value (hit_value)
   );

   lkv_recency u_recency (
      .clock     (clock),
      .reset     (reset),
      .op        (op),
      .hit_vec   (hit_vec),
      .valid_vec (valid_vec),
      .capacity  (capacity_ff),
      .slot_vec  (slot_vec)
   );

   // Put returns zero; a get returns the stored value or all ones on a miss
   always_comb begin
      if (is_put) begin
         rsp_read_value_in = PUT_VALUE;
      end else if (hit) begin
         rsp_read_value_in = hit_value;
      end else begin
         rsp_read_value_in = MISS_VALUE;
      end
   end

   // Load the result of a processed item, hold a stalled result, clear one that was taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_hit_ff        <= hit;
         rsp_read_value_ff <= rsp_read_value_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_read_value = rsp_read_value_ff;

   a_stall_only_when_blocked: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (stage_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("input stalled while the pipeline could move");

   a_processed_item_shows: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("processed item did not reach the result register");

   a_stalled_result_kept: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> (rsp_valid_ff && !$past(advance)
         |-> $stable(rsp_read_value_ff)))
      else $error("stalled result changed");

endmodule

`default_nettype wire
